>>> design/gabpk_pkg.sv
`timescale 1ns / 1ps
// shared types, register codes and arithmetic helpers for the bump pair kernel
// no dependencies

package gabpk_pkg;

	localparam int NUM_KINDS_DEF       = 3;
	localparam int POS_FRAC_BITS_DEF   = 16;
	localparam int EXP_TABLE_DEPTH_DEF = 256;

	localparam int MAX_KINDS  = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [30:0]     LOG2E_Q30 = 31'd1549082005;
	localparam longint unsigned LN2_Q62   = 64'd3196577161300663915;
	localparam longint unsigned ONE_Q30   = 64'd1073741824;
	localparam longint unsigned ONE_Q60   = 64'h1000_0000_0000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CUT_SQ0   = 3'd0,
		REG_CUT_SQ1   = 3'd1,
		REG_CUT_SQ2   = 3'd2,
		REG_STRENGTH0 = 3'd3,
		REG_STRENGTH1 = 3'd4,
		REG_STRENGTH2 = 3'd5,
		REG_CELL_VOL  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [23:0]        grid_tag;
		logic [15:0]        atom_tag;
		logic [1:0]         atom_kind;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [31:0] atom_x;
		logic signed [31:0] atom_y;
		logic signed [31:0] atom_z;
		logic signed [31:0] grad_x;
		logic signed [31:0] grad_y;
		logic signed [31:0] grad_z;
	} pair_in_t;

	typedef struct packed {
		logic [23:0]        out_grid_tag;
		logic [15:0]        out_atom_tag;
		logic               inside_cutoff;
		logic signed [31:0] chem_increment;
		logic signed [31:0] force_x_increment;
		logic signed [31:0] force_y_increment;
		logic signed [31:0] force_z_increment;
	} pair_out_t;

	// data that rides along the pipeline beside the arithmetic
	typedef struct packed {
		logic [23:0] grid_tag;
		logic [15:0] atom_tag;
		logic [1:0]  kind;
		logic        kind_ok;
		logic        in_cut;
		logic        far;
		logic [31:0] grad_x;
		logic [31:0] grad_y;
		logic [31:0] grad_z;
	} carry_t;

	// give a magnitude its sign and clamp to 32 bits
	function automatic logic [31:0] sat_mag(input logic [63:0] m, input logic pos);
		logic [31:0] res;
		if (pos) begin
			res = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
		end else begin
			res = (m > 64'h8000_0000) ? 32'h8000_0000 : (~m[31:0]) + 32'd1;
		end
		return res;
	endfunction

endpackage

>>> design/grid_atom_bump_pair_kernel_unit.sv
`timescale 1ns / 1ps
// top level of the grid point / atom bump pair kernel
// depends on gabpk_pkg and gabpk_div

// Usage
// A pair is transferred on a rising edge with start high; busy stays low, so
// a new pair may be offered every cycle and the unit sustains one pair per
// clock. Each pair yields exactly one result: done is high for one cycle
// with the result struct valid, transferred at the edge that ends that cycle.
// The pipeline holds 3 stages for distance and cutoff test, 32 for the
// ratio divider, 1 for setup, 29 for the exponent divider and 7 for
// table interpolation, scaling and the force products.
// Results leave in the order pairs came in. The receiver cannot stall.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// should happen only while no pair is in flight; index 7 is ignored.
// Reset clears the pipeline valid bits and returns every configuration
// register to its default (cutoffs and cell volume 1.0, strengths 1.0).

module grid_atom_bump_pair_kernel_unit #(
	parameter int NUM_KINDS       = gabpk_pkg::NUM_KINDS_DEF,
	parameter int POS_FRAC_BITS   = gabpk_pkg::POS_FRAC_BITS_DEF,
	parameter int EXP_TABLE_DEPTH = gabpk_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  gabpk_pkg::pair_in_t                 in_item,
	output logic                                done,
	output gabpk_pkg::pair_out_t                result,
	input  logic                                cfg_we,
	input  logic [gabpk_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gabpk_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int SQ_W  = 66 - POS_FRAC_BITS;
	localparam int RSQ_W = SQ_W + 2;
	localparam int IW    = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int P_W   = 24 + IW;
	localparam int CAR_W = $bits(gabpk_pkg::carry_t);

	localparam longint unsigned TAB_Q = gabpk_pkg::LN2_Q62 / EXP_TABLE_DEPTH;
	localparam longint unsigned TAB_R = gabpk_pkg::LN2_Q62 % EXP_TABLE_DEPTH;

	// configuration registers
	logic [31:0] cut_q [gabpk_pkg::MAX_KINDS];
	logic [31:0] eps_q [gabpk_pkg::MAX_KINDS];
	logic [31:0] vol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gabpk_pkg::MAX_KINDS; i++) begin
				cut_q[i] <= 32'd65536;
				eps_q[i] <= 32'd16777216;
			end
			vol_q <= 32'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gabpk_pkg::REG_CUT_SQ0:   cut_q[0] <= cfg_data;
				gabpk_pkg::REG_CUT_SQ1:   cut_q[1] <= cfg_data;
				gabpk_pkg::REG_CUT_SQ2:   cut_q[2] <= cfg_data;
				gabpk_pkg::REG_STRENGTH0: eps_q[0] <= cfg_data;
				gabpk_pkg::REG_STRENGTH1: eps_q[1] <= cfg_data;
				gabpk_pkg::REG_STRENGTH2: eps_q[2] <= cfg_data;
				gabpk_pkg::REG_CELL_VOL:  vol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// constant table of 2^(-k/depth), truncated series for e^x then reciprocal
	logic [31:0] tab [EXP_TABLE_DEPTH + 1];
	for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++) begin : g_tab
		localparam longint unsigned X  = (TAB_Q * k + (TAB_R * k) / EXP_TABLE_DEPTH) >> 32;
		localparam longint unsigned T1  = (gabpk_pkg::ONE_Q30 * X) >> 30;
		localparam longint unsigned T2  = ((T1 * X) >> 30) / 2;
		localparam longint unsigned T3  = ((T2 * X) >> 30) / 3;
		localparam longint unsigned T4  = ((T3 * X) >> 30) / 4;
		localparam longint unsigned T5  = ((T4 * X) >> 30) / 5;
		localparam longint unsigned T6  = ((T5 * X) >> 30) / 6;
		localparam longint unsigned T7  = ((T6 * X) >> 30) / 7;
		localparam longint unsigned T8  = ((T7 * X) >> 30) / 8;
		localparam longint unsigned T9  = ((T8 * X) >> 30) / 9;
		localparam longint unsigned T10 = ((T9 * X) >> 30) / 10;
		localparam longint unsigned T11 = ((T10 * X) >> 30) / 11;
		localparam longint unsigned T12 = ((T11 * X) >> 30) / 12;
		localparam longint unsigned T13 = ((T12 * X) >> 30) / 13;
		localparam longint unsigned T14 = ((T13 * X) >> 30) / 14;
		localparam longint unsigned T15 = ((T14 * X) >> 30) / 15;
		localparam longint unsigned T16 = ((T15 * X) >> 30) / 16;
		localparam longint unsigned T17 = ((T16 * X) >> 30) / 17;
		localparam longint unsigned T18 = ((T17 * X) >> 30) / 18;
		localparam longint unsigned T19 = ((T18 * X) >> 30) / 19;
		localparam longint unsigned T20 = ((T19 * X) >> 30) / 20;
		localparam longint unsigned T21 = ((T20 * X) >> 30) / 21;
		localparam longint unsigned T22 = ((T21 * X) >> 30) / 22;
		localparam longint unsigned T23 = ((T22 * X) >> 30) / 23;
		localparam longint unsigned T24 = ((T23 * X) >> 30) / 24;
		localparam longint unsigned SUM = gabpk_pkg::ONE_Q30 + T1 + T2 + T3 + T4 + T5 + T6
			+ T7 + T8 + T9 + T10 + T11 + T12 + T13 + T14 + T15 + T16 + T17 + T18
			+ T19 + T20 + T21 + T22 + T23 + T24;
		localparam logic [31:0] ENTRY = 32'(gabpk_pkg::ONE_Q60 / SUM);
		assign tab[k] = ENTRY;
	end

	// pipeline registers
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	gabpk_pkg::pair_in_t   item_s1;
	gabpk_pkg::carry_t     car_s2, car_s3, car_s4, car_s5, car_s6, car_s7, car_s8, car_s9;
	gabpk_pkg::carry_t     car_s10;
	logic [SQ_W-1:0]       sq_s2 [3];
	logic [31:0]           rsq_s3;
	logic [31:0]           cut_s3;
	logic [31:0]           s_s4;
	logic [32:0]           u_s4;
	logic [29:0]           y_s5;
	logic [31:0]           a_s6, b_s6;
	logic [23:0]           rem_s6;
	logic [5:0]            n_s6, n_s7;
	logic [31:0]           a_s7, dp_s7;
	logic [30:0]           f_s8;
	logic [31:0]           chem_s9;
	logic [31:0]           ev_s10;
	logic [31:0]           car_chem_s10;
	gabpk_pkg::pair_out_t  out_s11;

	// stage 1: coordinate differences
	logic signed [32:0] dif [3];
	logic [32:0]        dmag [3];
	logic [31:0]        pt [3];
	logic [31:0]        at [3];
	gabpk_pkg::carry_t  car_new;

	always_comb begin
		pt[0] = item_s1.point_x;
		pt[1] = item_s1.point_y;
		pt[2] = item_s1.point_z;
		at[0] = item_s1.atom_x;
		at[1] = item_s1.atom_y;
		at[2] = item_s1.atom_z;
		for (int c = 0; c < 3; c++) begin
			dif[c]  = $signed({pt[c][31], pt[c]}) - $signed({at[c][31], at[c]});
			dmag[c] = dif[c][32] ? 33'(-dif[c]) : 33'(dif[c]);
		end
		car_new.grid_tag = item_s1.grid_tag;
		car_new.atom_tag = item_s1.atom_tag;
		car_new.kind     = item_s1.atom_kind;
		car_new.kind_ok  = 32'(item_s1.atom_kind) < NUM_KINDS;
		car_new.in_cut   = 1'b0;
		car_new.far      = 1'b0;
		car_new.grad_x   = item_s1.grad_x;
		car_new.grad_y   = item_s1.grad_y;
		car_new.grad_z   = item_s1.grad_z;
	end

	// stage 3: squared distance and cutoff test
	logic [RSQ_W-1:0]  rsq;
	logic [31:0]       cut_sel;
	gabpk_pkg::carry_t car_cut;

	always_comb begin
		case (car_s2.kind)
			2'd0:    cut_sel = cut_q[0];
			2'd1:    cut_sel = cut_q[1];
			2'd2:    cut_sel = cut_q[2];
			default: cut_sel = '0;
		endcase
		rsq = RSQ_W'(sq_s2[0]) + RSQ_W'(sq_s2[1]) + RSQ_W'(sq_s2[2]);
		car_cut = car_s2;
		car_cut.in_cut = car_s2.kind_ok && (rsq < RSQ_W'(cut_sel));
	end

	// ratio s = rsq * 2^32 / cut
	logic              v_d1;
	logic [31:0]       s_d1;
	logic [CAR_W-1:0]  side_d1;
	gabpk_pkg::carry_t car_d1;

	gabpk_div #(
		.DIV_W  (32),
		.QUO_W  (32),
		.SIDE_W (CAR_W)
	) u_div_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.rem_init  (rsq_s3),
		.feed      (32'd0),
		.divisor   (cut_s3),
		.side_in   (CAR_W'(car_s3)),
		.out_valid (v_d1),
		.quo       (s_d1),
		.side_out  (side_d1)
	);

	assign car_d1 = gabpk_pkg::carry_t'(side_d1);

	// stage 4: u = 1 - s and the far test t >= 32
	logic [32:0]       u_new;
	gabpk_pkg::carry_t car_d1_far;

	always_comb begin
		u_new = 33'h1_0000_0000 - {1'b0, s_d1};
		car_d1_far = car_d1;
		car_d1_far.far = {6'd0, s_d1} >= {u_new, 5'd0};
	end

	// exponent t = s * 2^24 / u
	logic              v_d2;
	logic [28:0]       t_d2;
	logic [CAR_W-1:0]  side_d2;
	gabpk_pkg::carry_t car_d2;

	gabpk_div #(
		.DIV_W  (33),
		.QUO_W  (29),
		.SIDE_W (CAR_W)
	) u_div_expo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.rem_init  ({6'd0, s_s4[31:5]}),
		.feed      ({s_s4[4:0], 24'd0}),
		.divisor   (u_s4),
		.side_in   (CAR_W'(car_s4)),
		.out_valid (v_d2),
		.quo       (t_d2),
		.side_out  (side_d2)
	);

	assign car_d2 = gabpk_pkg::carry_t'(side_d2);

	// stage 6: table index and fraction
	logic [P_W-1:0] p;
	logic [IW-1:0]  idx;
	logic [IW-1:0]  idx1;

	always_comb begin
		p    = P_W'(y_s5[23:0]) * P_W'(EXP_TABLE_DEPTH);
		idx  = p[24 +: IW];
		idx1 = IW'(idx + 1'b1);
	end

	// stage 8: interpolated value shifted by the integer part
	logic [31:0] v_interp;
	logic        kill;

	always_comb begin
		v_interp = a_s7 - dp_s7;
		kill = !car_s7.in_cut || car_s7.far || (n_s7 >= 6'd31);
	end

	// stage 9: chemical potential increment
	logic [31:0] eps_sel;
	logic [31:0] eps_mag;
	logic [32:0] chem_m;

	always_comb begin
		case (car_s8.kind)
			2'd0:    eps_sel = eps_q[0];
			2'd1:    eps_sel = eps_q[1];
			2'd2:    eps_sel = eps_q[2];
			default: eps_sel = '0;
		endcase
		eps_mag = eps_sel[31] ? (~eps_sel) + 32'd1 : eps_sel;
		chem_m = 33'((63'(f_s8) * 63'(eps_mag)) >> 30);
	end

	// stage 10: energy times cell volume
	logic [31:0] chem_mag;
	logic [63:0] ev_m;

	always_comb begin
		chem_mag = chem_s9[31] ? (~chem_s9) + 32'd1 : chem_s9;
		ev_m = (64'(chem_mag) * 64'(vol_q)) >> POS_FRAC_BITS;
	end

	// stage 11: force increments
	logic [31:0] grad [3];
	logic [31:0] gmag [3];
	logic [31:0] ev_mag;
	logic [63:0] fm [3];
	logic [31:0] frc [3];

	always_comb begin
		grad[0] = car_s10.grad_x;
		grad[1] = car_s10.grad_y;
		grad[2] = car_s10.grad_z;
		ev_mag = ev_s10[31] ? (~ev_s10) + 32'd1 : ev_s10;
		for (int c = 0; c < 3; c++) begin
			gmag[c] = grad[c][31] ? (~grad[c]) + 32'd1 : grad[c];
			fm[c]   = (64'(gmag[c]) * 64'(ev_mag)) >> 24;
			frc[c]  = gabpk_pkg::sat_mag(fm[c], grad[c][31] ^ ev_s10[31]);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else begin
			v_s1  <= start & ~busy;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_d1;
			v_s5  <= v_d2;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		item_s1 <= in_item;

		car_s2 <= car_new;
		for (int c = 0; c < 3; c++) begin
			sq_s2[c] <= SQ_W'((66'(dmag[c]) * 66'(dmag[c])) >> POS_FRAC_BITS);
		end

		car_s3 <= car_cut;
		rsq_s3 <= rsq[31:0];
		cut_s3 <= cut_sel;

		car_s4 <= car_d1_far;
		s_s4   <= s_d1;
		u_s4   <= u_new;

		car_s5 <= car_d2;
		y_s5   <= 30'((60'(t_d2) * 60'(gabpk_pkg::LOG2E_Q30)) >> 30);

		car_s6 <= car_s5;
		a_s6   <= tab[idx];
		b_s6   <= tab[idx1];
		rem_s6 <= p[23:0];
		n_s6   <= y_s5[29:24];

		car_s7 <= car_s6;
		a_s7   <= a_s6;
		n_s7   <= n_s6;
		dp_s7  <= 32'((56'(a_s6 - b_s6) * 56'(rem_s6)) >> 24);

		car_s8 <= car_s7;
		f_s8   <= kill ? 31'd0 : 31'(v_interp >> n_s7);

		car_s9  <= car_s8;
		chem_s9 <= gabpk_pkg::sat_mag(64'(chem_m), eps_sel[31]);

		car_s10      <= car_s9;
		ev_s10       <= gabpk_pkg::sat_mag(ev_m, !chem_s9[31]);
		car_chem_s10 <= chem_s9;

		out_s11.out_grid_tag      <= car_s10.grid_tag;
		out_s11.out_atom_tag      <= car_s10.atom_tag;
		out_s11.inside_cutoff     <= car_s10.in_cut;
		out_s11.chem_increment    <= car_chem_s10;
		out_s11.force_x_increment <= frc[0];
		out_s11.force_y_increment <= frc[1];
		out_s11.force_z_increment <= frc[2];
	end

	assign done   = v_s11;
	assign result = out_s11;

endmodule

>>> design/gabpk_div.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per register stage
// depends on nothing; side data travels with each stage

module gabpk_div #(
	parameter int DIV_W  = 32,
	parameter int QUO_W  = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [DIV_W-1:0]  rem_init,
	input  logic [QUO_W-1:0]  feed,
	input  logic [DIV_W-1:0]  divisor,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [QUO_W-1:0]  quo,
	output logic [SIDE_W-1:0] side_out
);

	logic              vld_sn  [QUO_W];
	logic [DIV_W-1:0]  rem_sn  [QUO_W];
	logic [DIV_W-1:0]  dvs_sn  [QUO_W];
	logic [QUO_W-1:0]  feed_sn [QUO_W];
	logic [QUO_W-1:0]  quo_sn  [QUO_W];
	logic [SIDE_W-1:0] side_sn [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic              prv_vld;
		logic [DIV_W-1:0]  prv_rem;
		logic [DIV_W-1:0]  prv_dvs;
		logic [QUO_W-1:0]  prv_feed;
		logic [QUO_W-1:0]  prv_quo;
		logic [SIDE_W-1:0] prv_side;
		logic [DIV_W:0]    trial;
		logic              ge;
		logic [DIV_W-1:0]  nxt_rem;
		logic [QUO_W-1:0]  nxt_quo;

		if (k == 0) begin : g_first
			assign prv_vld  = in_valid;
			assign prv_rem  = rem_init;
			assign prv_dvs  = divisor;
			assign prv_feed = feed;
			assign prv_quo  = '0;
			assign prv_side = side_in;
		end else begin : g_next
			assign prv_vld  = vld_sn[k-1];
			assign prv_rem  = rem_sn[k-1];
			assign prv_dvs  = dvs_sn[k-1];
			assign prv_feed = feed_sn[k-1];
			assign prv_quo  = quo_sn[k-1];
			assign prv_side = side_sn[k-1];
		end

		always_comb begin
			trial = {prv_rem, prv_feed[QUO_W-1-k]};
			ge = trial >= {1'b0, prv_dvs};
			nxt_rem = ge ? DIV_W'(trial - {1'b0, prv_dvs}) : DIV_W'(trial);
			nxt_quo = prv_quo;
			nxt_quo[QUO_W-1-k] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k] <= 1'b0;
			end else begin
				vld_sn[k] <= prv_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_sn[k]  <= nxt_rem;
			dvs_sn[k]  <= prv_dvs;
			feed_sn[k] <= prv_feed;
			quo_sn[k]  <= nxt_quo;
			side_sn[k] <= prv_side;
		end
	end

	assign out_valid = vld_sn[QUO_W-1];
	assign quo       = quo_sn[QUO_W-1];
	assign side_out  = side_sn[QUO_W-1];

endmodule
